>>> src/dnsrp_pkg.sv
package dnsrp_pkg;

    localparam int FifoDepth = 4;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_NAME,
        PH_POINTER,
        PH_FIXED,
        PH_RDATA,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        EV_HEADER   = 2'd0,
        EV_QUESTION = 2'd1,
        EV_RECORD   = 2'd2,
        EV_ERROR    = 2'd3
    } event_kind_t;

    localparam logic [7:0] PtrMask     = 8'hc0;
    localparam logic [7:0] NameEnd     = 8'h00;
    localparam logic [15:0] TypeA      = 16'h0001;
    localparam logic [3:0] HeaderBytes = 4'd12;
    localparam logic [3:0] FixedBytes  = 4'd10;
    localparam logic [3:0] QFixedBytes = 4'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [1:0]  section;
        logic [15:0] entry_index;
        logic [15:0] word16_a;
        logic [15:0] word16_b;
        logic [31:0] word32_a;
        logic [31:0] word32_b;
        logic [15:0] record_data_length;
        logic        is_ipv4;
        logic        name_compressed;
        logic        message_error;
    } out_item_t;

endpackage

>>> src/dnsrp_front.sv
module dnsrp_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  dnsrp_pkg::in_item_t in_item,
    output logic                q_push,
    input  logic                q_full,
    output dnsrp_pkg::in_item_t q_item
);

    // input register: byte parked here until the queue has room
    logic               valid_reg;
    dnsrp_pkg::in_item_t item_reg;

    assign full   = valid_reg && q_full;
    assign q_push = valid_reg;
    assign q_item = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!full)
            valid_reg <= push;
    end

    always_ff @(posedge clk)
    begin
        if (!full && push)
            item_reg <= in_item;
    end

endmodule

>>> src/dnsrp_queue.sv
module dnsrp_queue #(
    parameter int Depth = dnsrp_pkg::FifoDepth
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr,
    output logic                wr_full,
    input  dnsrp_pkg::in_item_t wr_item,
    output logic                rd_valid,
    input  logic                rd,
    output dnsrp_pkg::in_item_t rd_item
);

    localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1;

    dnsrp_pkg::in_item_t mem [Depth];
    logic [Aw-1:0] wp_reg, rp_reg;
    logic [Aw:0]   cnt_reg;
    logic do_wr, do_rd;

    assign wr_full  = (cnt_reg == (Aw+1)'(Depth));
    assign rd_valid = (cnt_reg != '0);
    assign rd_item  = mem[rp_reg];
    assign do_wr    = wr && !wr_full;
    assign do_rd    = rd && rd_valid;

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wp_reg] <= wr_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_wr)
                wp_reg <= (wp_reg == Aw'(Depth - 1)) ? '0 : wp_reg + 1'b1;
            if (do_rd)
                rp_reg <= (rp_reg == Aw'(Depth - 1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (Aw+1)'(do_wr) - (Aw+1)'(do_rd);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) wr_full |-> cnt_reg != '0)
        else $error("queue full with zero count");
    assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && !do_rd) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("queue count lost a write");
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= (Aw+1)'(Depth))
        else $error("queue overfilled");

endmodule

>>> src/dnsrp_back.sv
module dnsrp_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_take,
    input  dnsrp_pkg::in_item_t  in_item,
    output logic                 empty,
    input  logic                 pop,
    output dnsrp_pkg::out_item_t out_item
);

    dnsrp_pkg::phase_t phase_reg, phase_next;
    logic [3:0]  fbc_reg, fbc_next;
    logic [15:0] cnt_reg [4];
    logic [15:0] cnt_next [4];
    logic [15:0] id_reg, id_next, flags_reg, flags_next;
    logic [1:0]  sec_reg, sec_next;
    logic [15:0] idx_reg, idx_next;
    logic [7:0]  nbs_reg, nbs_next;
    logic [5:0]  lbl_reg, lbl_next;
    logic        ptr_reg, ptr_next;
    logic [63:0] shift_reg, shift_next;
    logic [15:0] dleft_reg, dleft_next;
    logic [31:0] addr_reg, addr_next;
    logic        err_reg, err_next;
    logic [15:0] rlen_reg, rlen_next;

    logic                 ovalid_reg;
    dnsrp_pkg::out_item_t oitem_reg;
    dnsrp_pkg::out_item_t res;
    logic                 res_v;

    logic [7:0] b;
    logic       last;

    assign b       = in_item.data_byte;
    assign last    = in_item.last_byte;
    // output register frees when empty or being popped
    assign in_take = in_valid && (!ovalid_reg || pop);
    assign empty   = !ovalid_reg;
    assign out_item = oitem_reg;

    always_comb
    begin
        logic        name_done;
        logic [15:0] nidx;
        logic [1:0]  seek_from;
        logic        do_seek, do_begin, ip;
        logic [3:0]  i;
        logic [1:0]  k;

        phase_next = phase_reg;
        fbc_next   = fbc_reg;
        for (int s = 0; s < 4; s++)
            cnt_next[s] = cnt_reg[s];
        id_next    = id_reg;
        flags_next = flags_reg;
        sec_next   = sec_reg;
        idx_next   = idx_reg;
        nbs_next   = nbs_reg;
        lbl_next   = lbl_reg;
        ptr_next   = ptr_reg;
        shift_next = shift_reg;
        dleft_next = dleft_reg;
        addr_next  = addr_reg;
        err_next   = err_reg;
        rlen_next  = rlen_reg;
        res        = '0;
        res_v      = 1'b0;
        name_done  = 1'b0;
        nidx       = idx_reg + 16'd1;
        seek_from  = 2'd0;
        do_seek    = 1'b0;
        do_begin   = 1'b0;
        ip         = 1'b0;
        i          = fbc_reg;
        k          = 2'((i - 4'd4) >> 1);

        if (!err_reg)
        begin
            case (phase_reg)
                dnsrp_pkg::PH_HEADER:
                begin
                    if (i < 4'd2)
                        id_next = {id_reg[7:0], b};
                    else if (i < 4'd4)
                        flags_next = {flags_reg[7:0], b};
                    else
                        cnt_next[k] = {cnt_reg[k][7:0], b};
                    fbc_next = i + 4'd1;
                    if (i + 4'd1 >= dnsrp_pkg::HeaderBytes)
                    begin
                        res.event_kind = dnsrp_pkg::EV_HEADER;
                        res.word16_a   = id_next;
                        res.word16_b   = flags_next;
                        res.word32_a   = {cnt_next[0], cnt_next[1]};
                        res.word32_b   = {cnt_next[2], cnt_next[3]};
                        res_v          = 1'b1;
                        do_seek        = 1'b1;
                        seek_from      = 2'd0;
                    end
                end
                dnsrp_pkg::PH_NAME:
                begin
                    if (nbs_reg == 8'hff)
                        err_next = 1'b1;
                    else
                    begin
                        nbs_next = nbs_reg + 8'd1;
                        if (lbl_reg != '0)
                            lbl_next = lbl_reg - 6'd1;
                        else if (b == dnsrp_pkg::NameEnd)
                            name_done = 1'b1;
                        else if ((b & dnsrp_pkg::PtrMask) == dnsrp_pkg::PtrMask)
                            phase_next = dnsrp_pkg::PH_POINTER;
                        else
                            lbl_next = b[5:0];
                    end
                end
                dnsrp_pkg::PH_POINTER:
                begin
                    if (nbs_reg == 8'hff)
                        err_next = 1'b1;
                    else
                    begin
                        nbs_next  = nbs_reg + 8'd1;
                        ptr_next  = 1'b1;
                        name_done = 1'b1;
                    end
                end
                dnsrp_pkg::PH_FIXED:
                begin
                    if (i < 4'd8)
                        shift_next = {shift_reg[55:0], b};
                    else
                        rlen_next = {rlen_reg[7:0], b};
                    fbc_next = i + 4'd1;
                    res.section     = sec_reg;
                    res.entry_index = idx_reg;
                    if (sec_reg == 2'd0)
                    begin
                        if (i + 4'd1 >= dnsrp_pkg::QFixedBytes)
                        begin
                            res.event_kind      = dnsrp_pkg::EV_QUESTION;
                            res.word16_a        = shift_next[31:16];
                            res.word16_b        = shift_next[15:0];
                            res.name_compressed = ptr_reg;
                            res_v               = 1'b1;
                        end
                    end
                    else if (i + 4'd1 >= dnsrp_pkg::FixedBytes)
                    begin
                        dleft_next = rlen_next;
                        if (rlen_next == '0)
                        begin
                            res.event_kind         = dnsrp_pkg::EV_RECORD;
                            res.word16_a           = shift_next[63:48];
                            res.word16_b           = shift_next[47:32];
                            res.word32_a           = shift_next[31:0];
                            res.name_compressed    = ptr_reg;
                            res_v                  = 1'b1;
                        end
                        else
                            phase_next = dnsrp_pkg::PH_RDATA;
                    end
                end
                dnsrp_pkg::PH_RDATA:
                begin
                    addr_next  = {addr_reg[23:0], b};
                    dleft_next = dleft_reg - 16'd1;
                    if (dleft_next == '0)
                    begin
                        ip = (shift_reg[63:48] == dnsrp_pkg::TypeA) && (rlen_reg == 16'd4);
                        res.event_kind         = dnsrp_pkg::EV_RECORD;
                        res.section            = sec_reg;
                        res.entry_index        = idx_reg;
                        res.word16_a           = shift_reg[63:48];
                        res.word16_b           = shift_reg[47:32];
                        res.word32_a           = shift_reg[31:0];
                        res.word32_b           = ip ? addr_next : 32'd0;
                        res.record_data_length = rlen_reg;
                        res.is_ipv4            = ip;
                        res.name_compressed    = ptr_reg;
                        res_v                  = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase

            // entry finished: step index, maybe move to next section
            if (res_v && phase_reg != dnsrp_pkg::PH_HEADER)
            begin
                idx_next = nidx;
                if (nidx >= cnt_reg[sec_reg])
                begin
                    do_seek   = 1'b1;
                    seek_from = sec_reg + 2'd1;
                    if (sec_reg == 2'd3)
                        phase_next = dnsrp_pkg::PH_DONE;
                end
                else
                    do_begin = 1'b1;
            end

            if (do_seek && !(phase_reg != dnsrp_pkg::PH_HEADER && sec_reg == 2'd3))
            begin
                phase_next = dnsrp_pkg::PH_DONE;
                for (int s = 3; s >= 0; s--)
                begin
                    if (2'(s) >= seek_from && cnt_next[s] != '0)
                    begin
                        sec_next = 2'(s);
                        idx_next = '0;
                        do_begin = 1'b1;
                    end
                end
                if (!do_begin)
                    phase_next = dnsrp_pkg::PH_DONE;
            end

            if (do_begin)
            begin
                phase_next = dnsrp_pkg::PH_NAME;
                fbc_next   = '0;
                nbs_next   = '0;
                lbl_next   = '0;
                ptr_next   = 1'b0;
                shift_next = '0;
                dleft_next = '0;
                addr_next  = '0;
                rlen_next  = '0;
            end

            if (name_done)
            begin
                phase_next = dnsrp_pkg::PH_FIXED;
                fbc_next   = '0;
                shift_next = '0;
                rlen_next  = '0;
            end

            if (err_next)
            begin
                res             = '0;
                res.event_kind  = dnsrp_pkg::EV_ERROR;
                res.section     = sec_reg;
                res.entry_index = idx_reg;
                res.message_error = 1'b1;
                res_v           = 1'b1;
            end
        end

        if (last)
        begin
            if (!err_next && phase_next != dnsrp_pkg::PH_DONE)
            begin
                if (res_v)
                    res.message_error = 1'b1;
                else
                begin
                    res               = '0;
                    res.event_kind    = dnsrp_pkg::EV_ERROR;
                    res.message_error = 1'b1;
                    if (phase_next != dnsrp_pkg::PH_HEADER)
                    begin
                        res.section     = sec_next;
                        res.entry_index = idx_next;
                    end
                    res_v = 1'b1;
                end
            end
            phase_next = dnsrp_pkg::PH_HEADER;
            fbc_next   = '0;
            for (int s = 0; s < 4; s++)
                cnt_next[s] = '0;
            id_next    = '0;
            flags_next = '0;
            sec_next   = '0;
            idx_next   = '0;
            nbs_next   = '0;
            lbl_next   = '0;
            ptr_next   = 1'b0;
            shift_next = '0;
            dleft_next = '0;
            addr_next  = '0;
            err_next   = 1'b0;
            rlen_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= dnsrp_pkg::PH_HEADER;
            fbc_reg   <= '0;
            for (int s = 0; s < 4; s++)
                cnt_reg[s] <= '0;
            id_reg    <= '0;
            flags_reg <= '0;
            sec_reg   <= '0;
            idx_reg   <= '0;
            nbs_reg   <= '0;
            lbl_reg   <= '0;
            ptr_reg   <= 1'b0;
            shift_reg <= '0;
            dleft_reg <= '0;
            addr_reg  <= '0;
            err_reg   <= 1'b0;
            rlen_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                phase_reg <= phase_next;
                fbc_reg   <= fbc_next;
                for (int s = 0; s < 4; s++)
                    cnt_reg[s] <= cnt_next[s];
                id_reg    <= id_next;
                flags_reg <= flags_next;
                sec_reg   <= sec_next;
                idx_reg   <= idx_next;
                nbs_reg   <= nbs_next;
                lbl_reg   <= lbl_next;
                ptr_reg   <= ptr_next;
                shift_reg <= shift_next;
                dleft_reg <= dleft_next;
                addr_reg  <= addr_next;
                err_reg   <= err_next;
                rlen_reg  <= rlen_next;
            end
            if (in_take)
                ovalid_reg <= res_v;
            else if (pop)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take && res_v)
            oitem_reg <= res;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && !pop) |-> !in_take)
        else $error("result overwritten before it was taken");
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && last) |=> (phase_reg == dnsrp_pkg::PH_HEADER && !err_reg))
        else $error("message end did not restart the parser");
    assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && oitem_reg.event_kind == dnsrp_pkg::EV_ERROR) |-> oitem_reg.message_error)
        else $error("error result without error flag");

endmodule

>>> src/dns_response_record_parser_core.sv
// path: a byte's result reaches the result ports through the input register, the queue
// and the parser with its output register
// throughput: one byte per cycle; the parser advances whenever its result register is free
// names, fixed fields and record data all take one byte per cycle, no stalls of their own
// reset: rst_n asynchronous, clears queue, parser state and result valid; no clearing pass
module dns_response_record_parser_core #(
    parameter int FifoDepth = dnsrp_pkg::FifoDepth
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  dnsrp_pkg::in_item_t  in_item,
    output logic                 empty,
    input  logic                 pop,
    output dnsrp_pkg::out_item_t out_item
);

    logic                q_push, q_full, q_valid, q_take;
    dnsrp_pkg::in_item_t q_wr_item, q_rd_item;

    dnsrp_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .in_item (in_item),
        .q_push  (q_push),
        .q_full  (q_full),
        .q_item  (q_wr_item)
    );

    dnsrp_queue #(.Depth(FifoDepth)) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (q_push),
        .wr_full  (q_full),
        .wr_item  (q_wr_item),
        .rd_valid (q_valid),
        .rd       (q_take),
        .rd_item  (q_rd_item)
    );

    dnsrp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (q_valid),
        .in_take  (q_take),
        .in_item  (q_rd_item),
        .empty    (empty),
        .pop      (pop),
        .out_item (out_item)
    );

endmodule

>>> tb/sv/dns_parse_checker.sv
module dns_parse_checker
    import dnsrp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  logic      full,
    input  in_item_t  in_item,
    input  logic      empty,
    input  logic      pop,
    input  out_item_t out_item,
    output int        error_count,
    output int        pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    phase_t      phase;
    logic [3:0]  fcount;
    logic [15:0] counts [4];
    logic [15:0] msg_id;
    logic [15:0] msg_flags;
    logic [1:0]  cur_sec;
    logic [15:0] cur_idx;
    logic [7:0]  name_len;
    logic [5:0]  label_left;
    logic        ptr_seen;
    logic [63:0] fshift;
    logic [15:0] data_left;
    logic [31:0] addr;
    logic        err_lat;
    logic [15:0] rdlen;

    out_item_t expected_results [$];

    function automatic out_item_t make_result(logic [1:0] kind, logic [15:0] a,
        logic [15:0] b, logic [31:0] c, logic [31:0] d, logic [15:0] rdl,
        logic ip, logic comp, logic err);
        out_item_t r;
        r.event_kind = kind;
        r.section = (kind == EV_HEADER) ? 2'd0 : cur_sec;
        r.entry_index = (kind == EV_HEADER) ? 16'd0 : cur_idx;
        r.word16_a = a;
        r.word16_b = b;
        r.word32_a = c;
        r.word32_b = d;
        r.record_data_length = rdl;
        r.is_ipv4 = ip;
        r.name_compressed = comp;
        r.message_error = err;
        return r;
    endfunction

    task automatic clear_parser();
        phase = PH_HEADER;
        fcount = '0;
        for (int s = 0; s < 4; s++)
            counts[s] = '0;
        msg_id = '0;
        msg_flags = '0;
        cur_sec = '0;
        cur_idx = '0;
        name_len = '0;
        label_left = '0;
        ptr_seen = 1'b0;
        fshift = '0;
        data_left = '0;
        addr = '0;
        err_lat = 1'b0;
        rdlen = '0;
    endtask

    task automatic start_entry();
        phase = PH_NAME;
        fcount = '0;
        name_len = '0;
        label_left = '0;
        ptr_seen = 1'b0;
        fshift = '0;
        data_left = '0;
        addr = '0;
        rdlen = '0;
    endtask

    task automatic find_section(int from);
        for (int s = from; s < 4; s++)
        begin
            if (counts[s] != 0)
            begin
                cur_sec = s[1:0];
                cur_idx = '0;
                start_entry();
                return;
            end
        end
        phase = PH_DONE;
    endtask

    task automatic next_entry();
        cur_idx = cur_idx + 16'd1;
        if (cur_idx >= counts[cur_sec])
            find_section(int'(cur_sec) + 1);
        else
            start_entry();
    endtask

    task automatic parse_byte(logic [7:0] b, logic last);
        out_item_t r;
        logic      have;
        logic      name_done;
        logic      rec_done;
        logic      ip;
        int        k;
        have = 1'b0;
        name_done = 1'b0;
        rec_done = 1'b0;
        if (!err_lat)
        begin
            case (phase)
                PH_HEADER:
                begin
                    if (fcount < 2)
                        msg_id = {msg_id[7:0], b};
                    else if (fcount < 4)
                        msg_flags = {msg_flags[7:0], b};
                    else
                    begin
                        k = (int'(fcount) - 4) >> 1;
                        counts[k] = {counts[k][7:0], b};
                    end
                    fcount = fcount + 4'd1;
                    if (fcount >= HeaderBytes)
                    begin
                        r = make_result(EV_HEADER, msg_id, msg_flags,
                            {counts[0], counts[1]}, {counts[2], counts[3]},
                            '0, 1'b0, 1'b0, 1'b0);
                        have = 1'b1;
                        find_section(0);
                    end
                end
                PH_NAME:
                begin
                    if (name_len == 8'd255)
                        err_lat = 1'b1;
                    else
                    begin
                        name_len++;
                        if (label_left > 0)
                            label_left--;
                        else if (b == NameEnd)
                            name_done = 1'b1;
                        else if ((b & PtrMask) == PtrMask)
                            phase = PH_POINTER;
                        else
                            label_left = b[5:0];
                    end
                end
                PH_POINTER:
                begin
                    if (name_len == 8'd255)
                        err_lat = 1'b1;
                    else
                    begin
                        name_len++;
                        ptr_seen = 1'b1;
                        name_done = 1'b1;
                    end
                end
                PH_FIXED:
                begin
                    if (fcount < 8)
                        fshift = {fshift[55:0], b};
                    else
                        rdlen = {rdlen[7:0], b};
                    fcount = fcount + 4'd1;
                    if (cur_sec == 0)
                    begin
                        if (fcount >= QFixedBytes)
                        begin
                            r = make_result(EV_QUESTION, fshift[31:16], fshift[15:0],
                                '0, '0, '0, 1'b0, ptr_seen, 1'b0);
                            have = 1'b1;
                            next_entry();
                        end
                    end
                    else if (fcount >= FixedBytes)
                    begin
                        data_left = rdlen;
                        if (rdlen == 0)
                            rec_done = 1'b1;
                        else
                            phase = PH_RDATA;
                    end
                end
                PH_RDATA:
                begin
                    addr = {addr[23:0], b};
                    data_left = data_left - 16'd1;
                    if (data_left == 0)
                        rec_done = 1'b1;
                end
                default: ;
            endcase
            // record completion shared by zero-length and rdata paths
            if (rec_done)
            begin
                ip = (fshift[63:48] == TypeA) && (rdlen == 16'd4);
                r = make_result(EV_RECORD, fshift[63:48], fshift[47:32],
                    fshift[31:0], ip ? addr : 32'd0, rdlen, ip, ptr_seen, 1'b0);
                have = 1'b1;
                next_entry();
            end
            if (name_done)
            begin
                phase = PH_FIXED;
                fcount = '0;
                fshift = '0;
                rdlen = '0;
            end
            if (err_lat)
            begin
                r = make_result(EV_ERROR, '0, '0, '0, '0, '0, 1'b0, 1'b0, 1'b1);
                have = 1'b1;
            end
        end
        if (last)
        begin
            if (!err_lat && phase != PH_DONE)
            begin
                if (have)
                    r.message_error = 1'b1;
                else
                begin
                    r = make_result(EV_ERROR, '0, '0, '0, '0, '0, 1'b0, 1'b0, 1'b1);
                    if (phase == PH_HEADER)
                    begin
                        r.section = '0;
                        r.entry_index = '0;
                    end
                    have = 1'b1;
                end
            end
            clear_parser();
        end
        if (have)
            expected_results.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_parser();
            expected_results.delete();
            error_count <= 0;
            pending_count <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, out_item);
                    error_count <= error_count + 1;
                end
                else
                begin
                    if (expected_results[0] !== out_item)
                    begin
                        $display("%0t: mismatch expected %p actual %p", $time,
                            expected_results[0], out_item);
                        error_count <= error_count + 1;
                    end
                    void'(expected_results.pop_front());
                end
            end
            if (push && !full)
                parse_byte(in_item.data_byte, in_item.last_byte);
            pending_count <= expected_results.size();
        end
    end
endmodule

>>> tb/sv/tb.sv
module tb;
    import dnsrp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      push = 1'b0;
    logic      full;
    in_item_t  in_item = '0;
    logic      empty;
    logic      pop = 1'b0;
    out_item_t out_item;
    int        error_count;
    int        pending_count;
    int        send_idle = 0;
    int        recv_stall = 0;
    int        hold_cycles = 0;
    int        cycle_count = 0;
    logic [8:0] byte_stream [$];

    always #2 clk = ~clk;

    dns_response_record_parser_core i_dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
        .empty(empty), .pop(pop), .out_item(out_item)
    );

    dns_parse_checker i_checker (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
        .empty(empty), .pop(pop), .out_item(out_item),
        .error_count(error_count), .pending_count(pending_count)
    );

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 400000)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver: random stalls plus one long hold-off at the start of the first phase
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles--;
            pop <= 1'b0;
        end
        else
            pop <= ($urandom_range(99) >= recv_stall);
    end

    task automatic put_byte(logic [7:0] b);
        byte_stream.push_back({b, 1'b0});
    endtask

    task automatic put_word(logic [15:0] w);
        put_byte(w[15:8]);
        put_byte(w[7:0]);
    endtask

    task automatic end_message();
        byte_stream[$][0] = 1'b1;
    endtask

    task automatic put_name(bit compress, bit oversize);
        int labels;
        int len;
        labels = oversize ? 6 : $urandom_range(3);
        for (int l = 0; l < labels; l++)
        begin
            len = oversize ? 63 : $urandom_range(5);
            // reserved prefixes 01 and 10 act as plain labels
            put_byte({($urandom_range(3) == 0) ? 2'(1 + $urandom_range(1)) : 2'b00, 6'(len)});
            for (int c = 0; c < len; c++)
                put_byte(8'($urandom));
        end
        if (compress)
        begin
            put_byte(8'hc0 | 8'($urandom_range(63)));
            put_byte(8'($urandom));
        end
        else
            put_byte(NameEnd);
    endtask

    task automatic build_message(bit broken);
        int qd, an, ns, ar;
        int rdl;
        logic [15:0] rtype;
        qd = $urandom_range(2);
        an = $urandom_range(2);
        ns = $urandom_range(1);
        ar = $urandom_range(1);
        put_word(16'($urandom));
        put_word(16'($urandom));
        put_word(16'(qd));
        put_word(16'(an));
        put_word(16'(ns));
        put_word(16'(ar));
        for (int q = 0; q < qd; q++)
        begin
            put_name(1'($urandom_range(1)), 1'b0);
            put_word(16'($urandom));
            put_word(16'($urandom));
        end
        for (int r = 0; r < an + ns + ar; r++)
        begin
            put_name(1'($urandom_range(1)), $urandom_range(30) == 0);
            rtype = ($urandom_range(1)) ? TypeA : 16'($urandom);
            rdl = ($urandom_range(2) != 0) ? 4 : $urandom_range(6);
            put_word(rtype);
            put_word(16'($urandom));
            put_word(16'($urandom));
            put_word(16'($urandom));
            put_word(16'(rdl));
            for (int d = 0; d < rdl; d++)
                put_byte(8'($urandom));
        end
        if ($urandom_range(3) == 0)
            put_byte(8'($urandom));
        if (broken && byte_stream.size() > 1)
            void'(byte_stream.pop_back());
        end_message();
    endtask

    task automatic send_stream();
        logic [8:0] item;
        while (byte_stream.size() > 0)
        begin
            item = byte_stream.pop_front();
            while (send_idle > 0 && $urandom_range(99) < send_idle)
            begin
                push <= 1'b0;
                @(negedge clk);
            end
            push <= 1'b1;
            in_item <= {item[8:1], item[0]};
            @(posedge clk);
            while (full)
                @(posedge clk);
            @(negedge clk);
        end
        push <= 1'b0;
    endtask

    initial
    begin
        int sent;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        // directed: all-zero header, all-ones header cut short, lone byte
        for (int i = 0; i < 12; i++)
            put_byte(8'h00);
        end_message();
        for (int i = 0; i < 5; i++)
            put_byte(8'hff);
        end_message();
        put_byte(8'h5a);
        end_message();
        send_stream();
        sent = 0;
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle = (ph == 1 || ph == 3) ? ((ph == 3) ? 29 : 70) : 0;
            recv_stall = (ph == 2 || ph == 3) ? ((ph == 3) ? 29 : 70) : 0;
            if (ph == 0)
                hold_cycles = 60;
            while (sent < 262 * (ph + 1))
            begin
                if ($urandom_range(9) == 0)
                begin
                    for (int n = 0; n < 1 + $urandom_range(20); n++)
                        put_byte(8'($urandom));
                    end_message();
                end
                else
                    build_message($urandom_range(7) == 0);
                sent += byte_stream.size();
                send_stream();
            end
        end
        recv_stall = 0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
